// File: hdl/hit_pkg.sv
`default_nettype none

package hit_pkg;

    // Field and coefficient formats
    localparam int COORD_BITS = 12;
    localparam int COEF_BITS  = 21;
    localparam int ROW_W      = 3 * COEF_BITS;
    localparam int CFG_W      = ROW_W;
    localparam int CFG_IDX_W  = 3;
    localparam int LIMIT_W    = 24;
    localparam int ERR_W      = 24;

    // Threshold after reset: 4 pixels squared, 4 fractional bits
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    // Datapath widths
    localparam int OFF_ALIGN  = 10;
    localparam int FRAC_SHIFT = 8;
    localparam int PROD_W     = COEF_BITS + COORD_BITS + 1;
    localparam int DOT_W      = PROD_W + 2;
    localparam int NUM_W      = DOT_W + FRAC_SHIFT;
    localparam int QB         = 26;
    localparam int D_W        = QB + 2;
    localparam int DIFF_W     = 24;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int SUM_SHIFT  = 12;
    localparam int LANES      = 4;

    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};
    localparam logic [ERR_W-1:0]  ERR_MAX  = {ERR_W{1'b1}};

    // Pipeline depths
    localparam int PROJ_LAT = 3;
    localparam int ERR_LAT  = 5;
    localparam int SIDE_N   = PROJ_LAT + QB;
    localparam int PIPE_LAT = PROJ_LAT + QB + ERR_LAT;

    // Lane order in the divider
    localparam int LANE_FX = 0;
    localparam int LANE_FY = 1;
    localparam int LANE_RX = 2;
    localparam int LANE_RY = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FWD_ROW0    = 3'd0,
        REG_FWD_ROW1    = 3'd1,
        REG_FWD_ROW2    = 3'd2,
        REG_REV_ROW0    = 3'd3,
        REG_REV_ROW1    = 3'd4,
        REG_REV_ROW2    = 3'd5,
        REG_ERROR_LIMIT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] src_x;
        logic [COORD_BITS-1:0] src_y;
        logic [COORD_BITS-1:0] dst_x;
        logic [COORD_BITS-1:0] dst_y;
        logic                  end_of_set;
    } corr_word_t;

    typedef struct packed {
        logic             is_inlier;
        logic             degenerate;
        logic [ERR_W-1:0] error_sq;
        logic             last_of_set;
    } res_word_t;

    // One division in flight: partial remainder, divisor magnitude,
    // dividend bits still to shift in, quotient so far and flags
    typedef struct packed {
        logic [DOT_W-1:0] rem;
        logic [DOT_W-1:0] den;
        logic [QB-1:0]    nlow;
        logic [QB-1:0]    quo;
        logic             neg;
        logic             big;
        logic             zero;
    } div_lane_t;

    typedef div_lane_t [LANES-1:0] div_set_t;

endpackage

`default_nettype wire

// File: hdl/hit_proj.sv
`default_nettype none

// Maps one point through three matrix rows and sets up the two divisions
module hit_proj (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [hit_pkg::COORD_BITS-1:0] qx,
    input  wire logic [hit_pkg::COORD_BITS-1:0] qy,
    input  wire logic [hit_pkg::ROW_W-1:0]      row_a,
    input  wire logic [hit_pkg::ROW_W-1:0]      row_b,
    input  wire logic [hit_pkg::ROW_W-1:0]      row_c,
    output hit_pkg::div_lane_t                  lane_x,
    output hit_pkg::div_lane_t                  lane_y
);
    import hit_pkg::*;

    function automatic logic signed [COEF_BITS-1:0] coef(input logic [ROW_W-1:0] row,
                                                         input int col);
        coef = signed'(row[col*COEF_BITS +: COEF_BITS]);
    endfunction

    logic [ROW_W-1:0]                rows [3];
    logic signed [COORD_BITS:0]      xs;
    logic signed [COORD_BITS:0]      ys;

    logic signed [PROD_W-1:0]        px_reg  [3];
    logic signed [PROD_W-1:0]        py_reg  [3];
    logic signed [COEF_BITS-1:0]     off_reg [3];
    logic signed [DOT_W-1:0]         dot_reg [3];

    logic signed [NUM_W-1:0]         num     [2];
    logic [NUM_W-1:0]                num_mag [2];
    logic [DOT_W-1:0]                den_mag;
    logic                            w_neg;
    div_lane_t                       lane_next [2];
    div_lane_t                       lane_reg  [2];

    assign rows[0] = row_a;
    assign rows[1] = row_b;
    assign rows[2] = row_c;
    assign xs = signed'({1'b0, qx});
    assign ys = signed'({1'b0, qy});

    // Stage A: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                px_reg[r]  <= PROD_W'(coef(rows[r], 0)) * PROD_W'(xs);
                py_reg[r]  <= PROD_W'(coef(rows[r], 1)) * PROD_W'(ys);
                off_reg[r] <= coef(rows[r], 2);
            end
        end
    end

    // Stage B: row sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                dot_reg[r] <= DOT_W'(px_reg[r]) + DOT_W'(py_reg[r])
                            + (DOT_W'(off_reg[r]) <<< OFF_ALIGN);
            end
        end
    end

    // Stage C: magnitudes, overflow check, divider setup
    always_comb
    begin
        w_neg   = dot_reg[2][DOT_W-1];
        den_mag = w_neg ? DOT_W'(-dot_reg[2]) : DOT_W'(dot_reg[2]);
        for (int i = 0; i < 2; i++)
        begin
            num[i]     = NUM_W'(dot_reg[i]) <<< FRAC_SHIFT;
            num_mag[i] = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
            lane_next[i].big  = DOT_W'(num_mag[i][NUM_W-1:QB]) >= den_mag;
            lane_next[i].rem  = lane_next[i].big ? '0 : DOT_W'(num_mag[i][NUM_W-1:QB]);
            lane_next[i].den  = den_mag;
            lane_next[i].nlow = num_mag[i][QB-1:0];
            lane_next[i].quo  = '0;
            lane_next[i].neg  = num[i][NUM_W-1] ^ w_neg;
            lane_next[i].zero = (dot_reg[2] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg[0] <= lane_next[0];
            lane_reg[1] <= lane_next[1];
        end
    end

    assign lane_x = lane_reg[0];
    assign lane_y = lane_reg[1];

endmodule

`default_nettype wire

// File: hdl/hit_div_step.sv
`default_nettype none

// One restoring division step for every lane
module hit_div_step (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire hit_pkg::div_set_t set_in,
    output hit_pkg::div_set_t      set_out
);
    import hit_pkg::*;

    logic [DOT_W:0] trial [LANES];
    logic [DOT_W:0] den_x [LANES];
    logic           fits  [LANES];
    div_set_t       set_next;
    div_set_t       set_reg;

    always_comb
    begin
        set_next = set_in;
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {set_in[i].rem, set_in[i].nlow[QB-1]};
            den_x[i] = {1'b0, set_in[i].den};
            fits[i]  = trial[i] >= den_x[i];
            set_next[i].rem  = fits[i] ? DOT_W'(trial[i] - den_x[i]) : DOT_W'(trial[i]);
            set_next[i].nlow = {set_in[i].nlow[QB-2:0], 1'b0};
            set_next[i].quo  = {set_in[i].quo[QB-2:0], fits[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            set_reg <= set_next;
        end
    end

    assign set_out = set_reg;

endmodule

`default_nettype wire

// File: hdl/hit_err.sv
`default_nettype none

// Differences, squares, sum and threshold test
module hit_err (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire hit_pkg::div_set_t           lanes,
    input  wire hit_pkg::corr_word_t         side,
    input  wire logic [hit_pkg::LIMIT_W-1:0] error_limit,
    output hit_pkg::res_word_t               res
);
    import hit_pkg::*;

    logic [COORD_BITS-1:0]  pix [LANES];
    logic signed [D_W-1:0]  pix256 [LANES];
    logic signed [D_W-1:0]  qv [LANES];

    logic signed [D_W-1:0]  d_reg   [LANES];
    logic                   big_reg [LANES];
    logic [D_W-1:0]         mag     [LANES];
    logic [DIFF_W-1:0]      diff_reg [LANES];
    logic [SQ_W-1:0]        sq_reg  [LANES];
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-SUM_SHIFT-1:0] shifted;
    logic [ERR_W-1:0]       err;
    res_word_t              res_reg;

    logic [ERR_LAT-2:0]     degen_reg;
    logic [ERR_LAT-2:0]     last_reg;

    assign pix[LANE_FX] = side.dst_x;
    assign pix[LANE_FY] = side.dst_y;
    assign pix[LANE_RX] = side.src_x;
    assign pix[LANE_RY] = side.src_y;

    // Stage 1: signed difference to the partner point
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            pix256[i] = signed'(D_W'({pix[i], {FRAC_SHIFT{1'b0}}}));
            qv[i]     = signed'(D_W'(lanes[i].quo));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                d_reg[i]   <= lanes[i].neg ? pix256[i] + qv[i] : pix256[i] - qv[i];
                big_reg[i] <= lanes[i].big;
            end
            degen_reg <= {degen_reg[ERR_LAT-3:0],
                          lanes[0].zero | lanes[1].zero | lanes[2].zero | lanes[3].zero};
            last_reg  <= {last_reg[ERR_LAT-3:0], side.end_of_set};
        end
    end

    // Stage 2: magnitude and clamp
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mag[i] = d_reg[i][D_W-1] ? D_W'(-d_reg[i]) : D_W'(d_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                diff_reg[i] <= (big_reg[i] || mag[i] > D_W'(DIFF_MAX)) ? DIFF_MAX
                                                                      : mag[i][DIFF_W-1:0];
            end
        end
    end

    // Stage 3: squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sq_reg[i] <= diff_reg[i] * diff_reg[i];
            end
        end
    end

    // Stage 4: sum of both squared distances
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                     + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
        end
    end

    // Stage 5: scale, saturate, compare
    always_comb
    begin
        shifted = sum_reg[SUM_W-1:SUM_SHIFT];
        if (degen_reg[ERR_LAT-2] || shifted > (SUM_W-SUM_SHIFT)'(ERR_MAX))
        begin
            err = ERR_MAX;
        end
        else
        begin
            err = shifted[ERR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.is_inlier   <= !degen_reg[ERR_LAT-2] && (err < error_limit);
            res_reg.degenerate  <= degen_reg[ERR_LAT-2];
            res_reg.error_sq    <= err;
            res_reg.last_of_set <= last_reg[ERR_LAT-2];
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: hdl/homography_inlier_test_core.sv
`default_nettype none

// Channel   Handshake              Payload
// corr      corr_valid/corr_stall  corr_word (src/dst pixel pair, end_of_set)
// res       res_valid/res_stall    res_word (is_inlier, degenerate, error_sq, last)
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One correspondence per cycle while corr_stall is low; 3 projection stages,
// 26 restoring divider steps (one quotient bit each), 5 error stages and
// the output register. rst_n clears valid bits and loads the register
// defaults. A stalled result parks the next one in a skid register; only
// then does corr_stall rise and the whole pipeline hold.
module homography_inlier_test_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          corr_valid,
    output logic                               corr_stall,
    input  wire hit_pkg::corr_word_t           corr_word,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output hit_pkg::res_word_t                 res_word,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hit_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hit_pkg::CFG_W-1:0]     cfg_data
);
    import hit_pkg::*;

    logic [ROW_W-1:0]   fwd_reg [3];
    logic [ROW_W-1:0]   rev_reg [3];
    logic [LIMIT_W-1:0] limit_reg;

    logic               en;
    logic [PIPE_LAT-1:0] v_reg;
    corr_word_t         side_reg [SIDE_N];
    div_set_t           chain [QB+1];
    res_word_t          pipe_word;
    logic               pipe_v;

    logic               out_v_reg,  out_v_next;
    res_word_t          out_reg,    out_next;
    logic               skid_v_reg, skid_v_next;
    res_word_t          skid_reg,   skid_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                fwd_reg[i] <= '0;
                rev_reg[i] <= '0;
            end
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FWD_ROW0:    fwd_reg[0] <= cfg_data;
                REG_FWD_ROW1:    fwd_reg[1] <= cfg_data;
                REG_FWD_ROW2:    fwd_reg[2] <= cfg_data;
                REG_REV_ROW0:    rev_reg[0] <= cfg_data;
                REG_REV_ROW1:    rev_reg[1] <= cfg_data;
                REG_REV_ROW2:    rev_reg[2] <= cfg_data;
                REG_ERROR_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Pipeline advances unless the skid register is occupied
    assign en         = !skid_v_reg;
    assign corr_stall = skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PIPE_LAT-2:0], corr_valid};
        end
    end

    // Pixel coordinates ride alongside the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= corr_word;
            for (int i = 1; i < SIDE_N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Forward map of the source, inverse map of the target
    hit_proj u_proj_fwd (
        .clk    (clk),
        .en     (en),
        .qx     (corr_word.src_x),
        .qy     (corr_word.src_y),
        .row_a  (fwd_reg[0]),
        .row_b  (fwd_reg[1]),
        .row_c  (fwd_reg[2]),
        .lane_x (chain[0][LANE_FX]),
        .lane_y (chain[0][LANE_FY])
    );

    hit_proj u_proj_rev (
        .clk    (clk),
        .en     (en),
        .qx     (corr_word.dst_x),
        .qy     (corr_word.dst_y),
        .row_a  (rev_reg[0]),
        .row_b  (rev_reg[1]),
        .row_c  (rev_reg[2]),
        .lane_x (chain[0][LANE_RX]),
        .lane_y (chain[0][LANE_RY])
    );

    // Divider: one quotient bit per stage
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        hit_div_step u_step (
            .clk     (clk),
            .en      (en),
            .set_in  (chain[s]),
            .set_out (chain[s+1])
        );
    end

    hit_err u_err (
        .clk         (clk),
        .en          (en),
        .lanes       (chain[QB]),
        .side        (side_reg[SIDE_N-1]),
        .error_limit (limit_reg),
        .res         (pipe_word)
    );

    assign pipe_v = v_reg[PIPE_LAT-1];

    // Output register with skid stage
    always_comb
    begin
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        skid_v_next = skid_v_reg;
        skid_next   = skid_reg;
        if (!out_v_reg || !res_stall)
        begin
            if (skid_v_reg)
            begin
                out_next    = skid_reg;
                out_v_next  = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                out_next   = pipe_word;
                out_v_next = pipe_v;
            end
        end
        else if (pipe_v && !skid_v_reg)
        begin
            skid_next   = pipe_word;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res_valid = out_v_reg;
    assign res_word  = out_reg;

`ifndef SYNTHESIS
    // Skid holds a word only behind a waiting output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid word without output word");

    // Skid fills only when the output word was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && res_stall))
        else $error("skid filled without stall");

    // A degenerate word is never an inlier
    a_degen_not_inlier: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.degenerate) |-> !res_word.is_inlier)
        else $error("degenerate word flagged as inlier");

    // A degenerate word carries the saturated error
    a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.degenerate) |-> (res_word.error_sq == ERR_MAX))
        else $error("degenerate word without saturated error");
`endif

endmodule

`default_nettype wire
